// ===== hw/rtl/rpbg_pkg.sv =====
// Shared constants and types for the RSA pseudorandom bit generator.
package rpbg_pkg;
    localparam int VALUE_BITS_DEF = 63;
    localparam int MOD_W = 63;
    localparam int EXP_W = 64;
    localparam int CNT_W = 32;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 64;

    localparam logic [CFG_IDX_W-1:0] REG_MODULUS   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_EXPONENT  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SEED      = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BIT_COUNT = 2'd3;

    typedef enum logic [2:0] {
        t_IDLE, t_RED, t_EXP_BIT, t_MUL, t_SQR, t_OUT
    } t_state;

    // control from sequencer to the cell row
    typedef struct packed {
        logic load;   // load operands, clear accumulator
        logic step;   // one add-double step
    } t_mul_ctrl;
endpackage

// ===== hw/rtl/rpbg_cell.sv =====
// One bit cell of the add-and-double chain: a carry/borrow ripple slice.
module rpbg_cell (
    input  logic i_a,      // addend bit
    input  logic i_b,      // augend bit
    input  logic i_cin,
    input  logic i_m,      // modulus bit
    input  logic i_bin,    // borrow in
    output logic o_s,
    output logic o_cout,
    output logic o_d,      // difference bit of s - m
    output logic o_bout
);
    always_comb begin
        o_s    = i_a ^ i_b ^ i_cin;
        o_cout = (i_a & i_b) | (i_cin & (i_a ^ i_b));
        o_d    = o_s ^ i_m ^ i_bin;
        o_bout = (~o_s & i_m) | (i_bin & ~(o_s ^ i_m));
    end
endmodule

// ===== hw/rtl/rpbg_addmod.sv =====
// Row of cells forming (x + y) mod m for x, y < m.
module rpbg_addmod #(
    parameter int W = rpbg_pkg::VALUE_BITS_DEF
) (
    input  logic [W-1:0] i_x,
    input  logic [W-1:0] i_y,
    input  logic [W-1:0] i_m,
    output logic [W-1:0] o_r
);
    logic [W:0] w_c;
    logic [W:0] w_b;
    logic [W-1:0] w_s;
    logic [W-1:0] w_d;
    assign w_c[0] = 1'b0;
    assign w_b[0] = 1'b0;
    for (genvar g = 0; g < W; g++) begin : g_cell
        rpbg_cell u_cell (
            .i_a(i_x[g]), .i_b(i_y[g]), .i_cin(w_c[g]), .i_m(i_m[g]), .i_bin(w_b[g]),
            .o_s(w_s[g]), .o_cout(w_c[g+1]), .o_d(w_d[g]), .o_bout(w_b[g+1])
        );
    end
    // sum >= m when it carried out or the subtract did not borrow
    assign o_r = (w_c[W] | ~w_b[W]) ? w_d : w_s;
endmodule

// ===== hw/rtl/rpbg_mulmod.sv =====
// Add-and-double modular multiplier, one multiplier bit per cycle while step is asserted.
module rpbg_mulmod #(
    parameter int W = rpbg_pkg::VALUE_BITS_DEF
) (
    input  logic               i_clk,
    input  rpbg_pkg::t_mul_ctrl i_ctrl,
    input  logic [W-1:0]       i_a,
    input  logic [W-1:0]       i_b,
    input  logic [W-1:0]       i_m,
    output logic [W-1:0]       o_p,
    output logic               o_zero   // multiplier bits exhausted
);
    logic [W-1:0] r_a, r_b, r_acc;
    logic [W-1:0] w_sum, w_dbl;

    rpbg_addmod #(.W(W)) u_acc (.i_x(r_acc), .i_y(r_a), .i_m(i_m), .o_r(w_sum));
    rpbg_addmod #(.W(W)) u_dbl (.i_x(r_a), .i_y(r_a), .i_m(i_m), .o_r(w_dbl));

    always_ff @(posedge i_clk) begin
        if (i_ctrl.load) begin
            r_a   <= i_a;
            r_b   <= i_b;
            r_acc <= '0;
        end else if (i_ctrl.step) begin
            if (r_b[0]) r_acc <= w_sum;
            r_a <= w_dbl;
            r_b <= r_b >> 1;
        end
    end
    assign o_p    = r_acc;
    assign o_zero = (r_b == '0);
endmodule

// ===== hw/rtl/rsa_pseudorandom_bit_generator_core.sv =====
// Top level of the RSA pseudorandom bit generator core.
// Usage:
//   Configure modulus, exponent, seed and bit_count through the write port
//   (i_cfg_we, i_cfg_idx, i_cfg_data) while the core is idle.
//   Each transfer on the input channel (i_valid/o_ready, field i_restart)
//   advances the generator one step s = s^e mod N and produces one result
//   transfer (o_valid/i_ready) carrying random_bit, value, period,
//   period_found and last_bit.
// Timing:
//   Each modular multiply runs one multiplier bit per cycle through the row of
//   add-double cells. A step first reduces the base mod N with one such
//   multiply, then does square-and-multiply, one exponent bit per pass; one
//   item is in flight at a time.
// Reset:
//   Synchronous active-low reset restores default registers and clears the
//   generator state; the next step then starts from the seed.
// Stall:
//   The result is held in the output register until taken; o_ready stays low
//   until then.
module rsa_pseudorandom_bit_generator_core #(
    parameter int VALUE_BITS = rpbg_pkg::VALUE_BITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [rpbg_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [rpbg_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                           i_valid,
    output logic                           o_ready,
    input  logic                           i_restart,
    output logic                           o_valid,
    input  logic                           i_ready,
    output logic                           o_random_bit,
    output logic [rpbg_pkg::MOD_W-1:0]      o_value,
    output logic [rpbg_pkg::MOD_W-1:0]      o_period,
    output logic                           o_period_found,
    output logic                           o_last_bit
);
    localparam int W = VALUE_BITS;
    localparam int MW = rpbg_pkg::MOD_W;
    localparam int EW = rpbg_pkg::EXP_W;
    localparam int CW = rpbg_pkg::CNT_W;

    // configuration registers
    logic [MW-1:0] r_modulus, r_seed;
    logic [EW-1:0] r_exponent;
    logic [CW-1:0] r_bit_count;

    // generator state
    logic [W-1:0]  r_cur, r_first;
    logic [MW-1:0] r_period;
    logic          r_done, r_started;
    logic [CW-1:0] r_bits;

    // step working registers
    rpbg_pkg::t_state r_state, n_state;
    logic [W-1:0]  r_base, r_acc, r_m;
    logic [EW-1:0] r_e;
    logic          r_start_step;
    logic [MW-1:0] r_o_value, r_o_period;
    logic          r_o_found, r_o_last;

    rpbg_pkg::t_mul_ctrl w_ctrl;
    logic [W-1:0] w_mul_a, w_mul_b, w_p;
    logic         w_zero;
    logic [W-1:0] w_m, w_seed_red, w_cur_red, w_src, w_one;
    logic         w_take;

    assign w_take = i_valid && o_ready;
    assign w_m = (r_modulus[W-1:0] == '0) ? {{(W-1){1'b0}}, 1'b1} : r_modulus[W-1:0];
    // the base is reduced by multiplying 1 mod m by it, bit by bit
    assign w_one = (w_m == {{(W-1){1'b0}}, 1'b1}) ? '0 : {{(W-1){1'b0}}, 1'b1};
    assign w_seed_red = r_seed[W-1:0];
    assign w_cur_red = r_cur;
    assign w_src = (i_restart || !r_started) ? w_seed_red : w_cur_red;

    // multiplier operands: reduce base, multiply by base for acc, then square base
    assign w_mul_a = (r_state == rpbg_pkg::t_RED) ? r_acc : r_base;
    assign w_mul_b = (r_state == rpbg_pkg::t_MUL) ? r_acc : r_base;

    rpbg_mulmod #(.W(W)) u_mul (
        .i_clk(i_clk), .i_ctrl(w_ctrl), .i_a(w_mul_a), .i_b(w_mul_b),
        .i_m(r_m), .o_p(w_p), .o_zero(w_zero)
    );

    logic r_busy; // multiplier pass running inside RED/MUL/SQR

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            rpbg_pkg::t_IDLE:    if (w_take) n_state = rpbg_pkg::t_RED;
            rpbg_pkg::t_RED:     if (r_busy && w_zero) n_state = rpbg_pkg::t_EXP_BIT;
            rpbg_pkg::t_EXP_BIT: begin
                if (r_e == '0) n_state = rpbg_pkg::t_OUT;
                else if (r_e[0]) n_state = rpbg_pkg::t_MUL;
                else n_state = rpbg_pkg::t_SQR;
            end
            rpbg_pkg::t_MUL:     if (r_busy && w_zero) n_state = rpbg_pkg::t_SQR;
            rpbg_pkg::t_SQR:     if (r_busy && w_zero) n_state = rpbg_pkg::t_EXP_BIT;
            rpbg_pkg::t_OUT:     if (i_ready) n_state = rpbg_pkg::t_IDLE;
            default:             n_state = rpbg_pkg::t_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb begin
        w_ctrl.load = 1'b0;
        w_ctrl.step = 1'b0;
        o_ready = 1'b0;
        o_valid = 1'b0;
        case (r_state)
            rpbg_pkg::t_IDLE: o_ready = 1'b1;
            rpbg_pkg::t_RED, rpbg_pkg::t_MUL, rpbg_pkg::t_SQR: begin
                w_ctrl.load = !r_busy;
                w_ctrl.step = r_busy;
            end
            rpbg_pkg::t_OUT: o_valid = 1'b1;
            default: ;
        endcase
    end

    logic [W-1:0] w_s;
    assign w_s = r_acc;
    logic [MW-1:0] w_s_ext;
    assign w_s_ext = MW'(w_s);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_modulus   <= MW'(3);
            r_exponent  <= EW'(3);
            r_seed      <= MW'(2);
            r_bit_count <= CW'(1);
            r_state     <= rpbg_pkg::t_IDLE;
            r_busy      <= 1'b0;
            r_cur       <= '0;
            r_first     <= '0;
            r_period    <= MW'(1);
            r_done      <= 1'b0;
            r_started   <= 1'b0;
            r_bits      <= '0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    rpbg_pkg::REG_MODULUS:   r_modulus   <= i_cfg_data[MW-1:0];
                    rpbg_pkg::REG_EXPONENT:  r_exponent  <= i_cfg_data;
                    rpbg_pkg::REG_SEED:      r_seed      <= i_cfg_data[MW-1:0];
                    rpbg_pkg::REG_BIT_COUNT: r_bit_count <= i_cfg_data[CW-1:0];
                    default: ;
                endcase
            end
            case (r_state)
                rpbg_pkg::t_RED, rpbg_pkg::t_MUL, rpbg_pkg::t_SQR:
                    r_busy <= !(r_busy && w_zero);
                default: r_busy <= 1'b0;
            endcase
            // finish: update generator state as the result is formed
            if (r_state == rpbg_pkg::t_EXP_BIT && r_e == '0) begin
                r_cur <= w_s;
                if (r_start_step) begin
                    r_first   <= w_s;
                    r_period  <= MW'(1);
                    r_done    <= 1'b0;
                    r_bits    <= CW'(1);
                    r_started <= 1'b1;
                end else begin
                    if (!r_done) begin
                        if (w_s == r_first) r_done <= 1'b1;
                        else if (r_period != '1) r_period <= r_period + MW'(1);
                    end
                    if (r_bits != '1) r_bits <= r_bits + CW'(1);
                end
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (r_state == rpbg_pkg::t_IDLE && w_take) begin
            r_m          <= w_m;
            r_e          <= r_exponent;
            r_start_step <= i_restart || !r_started;
            // acc = 1 mod m; base is reduced by the first multiplier pass
            r_acc        <= w_one;
            r_base       <= w_src;
        end
        if (r_state == rpbg_pkg::t_RED && r_busy && w_zero) r_base <= w_p;
        if (r_state == rpbg_pkg::t_MUL && r_busy && w_zero) r_acc <= w_p;
        if (r_state == rpbg_pkg::t_SQR && r_busy && w_zero) begin
            r_base <= w_p;
            r_e    <= r_e >> 1;
        end
    end

    // output register, loaded when the step completes and held until taken
    always_ff @(posedge i_clk) begin
        if (r_state == rpbg_pkg::t_EXP_BIT && r_e == '0) begin
            r_o_value <= w_s_ext;
            if (r_start_step) begin
                r_o_period <= MW'(1);
                r_o_found  <= 1'b0;
                r_o_last   <= (r_bit_count == CW'(1));
            end else begin
                r_o_period <= (!r_done && w_s != r_first && r_period != '1)
                              ? r_period + MW'(1) : r_period;
                r_o_found  <= r_done || (w_s == r_first);
                r_o_last   <= (((r_bits != '1) ? r_bits + CW'(1) : r_bits) == r_bit_count);
            end
        end
    end

    assign o_random_bit   = r_o_value[0];
    assign o_value        = r_o_value;
    assign o_period       = r_o_period;
    assign o_period_found = r_o_found;
    assign o_last_bit     = r_o_last;
endmodule

// ===== test/rsa_pseudorandom_bit_generator_core_check.sv =====
// Result checker for the RSA pseudorandom bit generator core.
module rsa_pseudorandom_bit_generator_core_check (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [rpbg_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [rpbg_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                            i_valid,
    input  logic                            i_ready_in,
    input  logic                            i_restart,
    input  logic                            i_valid_out,
    input  logic                            i_ready,
    input  logic                            i_random_bit,
    input  logic [rpbg_pkg::MOD_W-1:0]      i_value,
    input  logic [rpbg_pkg::MOD_W-1:0]      i_period,
    input  logic                            i_period_found,
    input  logic                            i_last_bit,
    output int                              o_fail_count,
    output int                              o_pending,
    output int                              o_results,
    output int                              o_periods
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [62:0] CNT_SAT = {63{1'b1}};
    localparam logic [31:0] BITS_SAT = 32'hFFFF_FFFF;

    typedef struct packed {
        logic        random_bit;
        logic [62:0] value;
        logic [62:0] period;
        logic        period_found;
        logic        last_bit;
    } gen_result_t;

    logic [62:0] modulus_q, seed_q, cur_q, first_q, period_q;
    logic [63:0] exponent_q;
    logic [31:0] bit_count_q, bits_q;
    logic        done_q, started_q;
    gen_result_t want_q[$];

    function automatic logic [62:0] mul_mod(logic [62:0] a, logic [62:0] b, logic [62:0] m);
        logic [127:0] prod;
        prod = {65'd0, a} * {65'd0, b};
        return 63'(prod % {65'd0, m});
    endfunction

    function automatic logic [62:0] pow_mod(logic [62:0] b, logic [63:0] e, logic [62:0] m);
        logic [62:0] acc;
        logic [62:0] sq;
        acc = 63'd1 % m;
        sq  = b % m;
        for (int i = 0; i < 64; i++) begin
            if (e[i]) acc = mul_mod(acc, sq, m);
            sq = mul_mod(sq, sq, m);
        end
        return acc;
    endfunction

    // advance the generator copy and return the result it must produce
    function automatic gen_result_t next_result(logic restart);
        logic [62:0] m;
        logic [62:0] s;
        gen_result_t r;
        m = (modulus_q == 0) ? 63'd1 : modulus_q;
        if (restart || !started_q) begin
            s = pow_mod(seed_q, exponent_q, m);
            first_q = s;
            period_q = 63'd1;
            done_q = 1'b0;
            bits_q = 32'd1;
            started_q = 1'b1;
        end else begin
            s = pow_mod(cur_q, exponent_q, m);
            if (!done_q) begin
                if (s == first_q) done_q = 1'b1;
                else if (period_q != CNT_SAT) period_q++;
            end
            if (bits_q != BITS_SAT) bits_q++;
        end
        cur_q = s;
        r.random_bit = s[0];
        r.value = s;
        r.period = period_q;
        r.period_found = done_q;
        r.last_bit = (bits_q == bit_count_q);
        return r;
    endfunction

    always @(posedge i_clk) begin
        gen_result_t got, want;
        if (!i_rst_n) begin
            modulus_q = 63'd3; exponent_q = 64'd3; seed_q = 63'd2; bit_count_q = 32'd1;
            cur_q = '0; first_q = '0; period_q = 63'd1; done_q = 1'b0; started_q = 1'b0;
            bits_q = '0;
            want_q.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    rpbg_pkg::REG_MODULUS:   modulus_q = i_cfg_data[62:0];
                    rpbg_pkg::REG_EXPONENT:  exponent_q = i_cfg_data;
                    rpbg_pkg::REG_SEED:      seed_q = i_cfg_data[62:0];
                    rpbg_pkg::REG_BIT_COUNT: bit_count_q = i_cfg_data[31:0];
                    default: ;
                endcase
            end
            if (i_valid && i_ready_in) want_q.push_back(next_result(i_restart));
            if (i_valid_out && i_ready) begin
                got = '{i_random_bit, i_value, i_period, i_period_found, i_last_bit};
                o_results++;
                if (i_period_found) o_periods++;
                if (want_q.size() == 0) begin
                    o_fail_count++;
                    if (o_fail_count <= 10) $display("unexpected result %p", got);
                end else begin
                    want = want_q.pop_front();
                    if (got !== want) begin
                        o_fail_count++;
                        if (o_fail_count <= 10)
                            $display("mismatch: expected %p got %p", want, got);
                    end
                end
            end
        end
        o_pending = want_q.size();
    end
endmodule

// ===== test/rsa_pseudorandom_bit_generator_core_test.sv =====
// Stimulus and verdict for the RSA pseudorandom bit generator core.
module rsa_pseudorandom_bit_generator_core_test;
    timeunit 1ns;
    timeprecision 1ps;

    // allow several times the length of one step without a transfer
    localparam int STALL_LIMIT = 60000;

    logic i_clk = 0, i_rst_n = 0;
    logic i_cfg_we = 0;
    logic [rpbg_pkg::CFG_IDX_W-1:0] i_cfg_idx = rpbg_pkg::REG_MODULUS;
    logic [rpbg_pkg::CFG_DATA_W-1:0] i_cfg_data = '0;
    logic i_valid = 0, i_restart = 0, i_ready = 1;
    logic o_ready, o_valid, o_random_bit, o_period_found, o_last_bit;
    logic [rpbg_pkg::MOD_W-1:0] o_value, o_period;
    int fail_count, pending, results, periods;
    int idle_cycles = 0;
    bit quiet = 0;

    always begin
        #10 i_clk = 1;
        #10 i_clk = 0;
    end

    rsa_pseudorandom_bit_generator_core uut (.*);

    rsa_pseudorandom_bit_generator_core_check checker_i (
        .i_clk, .i_rst_n, .i_cfg_we, .i_cfg_idx, .i_cfg_data,
        .i_valid, .i_ready_in(o_ready), .i_restart,
        .i_valid_out(o_valid), .i_ready,
        .i_random_bit(o_random_bit), .i_value(o_value), .i_period(o_period),
        .i_period_found(o_period_found), .i_last_bit(o_last_bit),
        .o_fail_count(fail_count), .o_pending(pending),
        .o_results(results), .o_periods(periods)
    );

    // watchdog: count cycles with no transfer on either channel
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready)) idle_cycles = 0;
        else idle_cycles++;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("timeout after %0d cycles without a transfer", idle_cycles);
            $display("rsa_pseudorandom_bit_generator_core test failed");
            $finish;
        end
    end

    // stall the result side in random bursts
    initial begin
        forever begin
            @(negedge i_clk);
            if (!quiet && $urandom_range(0, 2) == 0) begin
                i_ready <= 0;
                repeat ($urandom_range(1, 11)) @(negedge i_clk);
            end
            i_ready <= 1;
        end
    end

    // push one step, optionally after an idle burst; hold valid until the transfer
    task automatic push_step(bit restart);
        @(negedge i_clk);
        if (!quiet && $urandom_range(0, 2) == 0) begin
            i_valid <= 0;
            repeat ($urandom_range(1, 11)) @(negedge i_clk);
        end
        i_valid <= 1;
        i_restart <= restart;
        do @(posedge i_clk); while (!o_ready);
    endtask

    // drop valid and let every step drain before touching registers
    task automatic drain;
        @(negedge i_clk);
        i_valid <= 0;
        while (pending != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic set_regs(logic [62:0] m, logic [63:0] e, logic [62:0] s, logic [31:0] n);
        @(negedge i_clk);
        i_cfg_we <= 1; i_cfg_idx <= rpbg_pkg::REG_MODULUS; i_cfg_data <= {1'b0, m};
        @(negedge i_clk);
        i_cfg_idx <= rpbg_pkg::REG_EXPONENT; i_cfg_data <= e;
        @(negedge i_clk);
        i_cfg_idx <= rpbg_pkg::REG_SEED; i_cfg_data <= {1'b0, s};
        @(negedge i_clk);
        i_cfg_idx <= rpbg_pkg::REG_BIT_COUNT; i_cfg_data <= {32'd0, n};
        @(negedge i_clk);
        i_cfg_we <= 0;
    endtask

    function automatic logic [62:0] rand63();
        return 63'({$urandom(), $urandom()});
    endfunction

    // small semiprimes keep the orbit short so the period flag is reached
    logic [62:0] semiprimes[8] = '{33, 35, 55, 77, 91, 143, 187, 323};

    initial begin
        logic [62:0] m;
        logic [63:0] e;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1;

        // reset defaults: first step starts from the seed even without restart
        push_step(0); push_step(0); push_step(1);
        drain();
        // zero and one modulus collapse every value to zero
        set_regs(63'd0, 64'd5, 63'd7, 32'd0);
        push_step(1); push_step(0);
        drain();
        set_regs(63'd1, 64'd3, {63{1'b1}}, 32'hFFFF_FFFF);
        push_step(0); push_step(0);
        drain();
        // zero exponent yields one; modulus two, seed zero
        set_regs(63'd2, 64'd0, 63'd0, 32'd2);
        push_step(1); push_step(0); push_step(0);
        drain();
        // full-width operands everywhere
        set_regs({63{1'b1}}, {64{1'b1}}, {63{1'b1}}, 32'd2);
        push_step(1); push_step(0); push_step(0);
        drain();
        set_regs({63{1'b1}} - 63'd24, 64'd1, 63'd0, 32'd3);
        push_step(1); push_step(0); push_step(0);
        drain();
        set_regs(63'd55, 64'd3, 63'd2, 32'd4);
        repeat (6) push_step(0);
        drain();

        // random phases: mostly long runs with rare restarts; the last one without idling
        for (int ph = 0; ph < 6; ph++) begin
            if (ph == 5) quiet = 1;
            if ($urandom_range(0, 3) == 0) m = rand63();
            else m = semiprimes[$urandom_range(0, 7)];
            e = ($urandom_range(0, 3) == 0) ? {$urandom(), $urandom()}
                                            : 64'($urandom_range(1, 17));
            set_regs(m, e, rand63() >> $urandom_range(0, 62), $urandom_range(1, 12));
            repeat (16) push_step($urandom_range(0, 9) == 0);
            drain();
        end

        $display("%0d steps checked, %0d with the period flag set, over 13 register settings",
                 results, periods);
        if (fail_count == 0) begin
            $display("rsa_pseudorandom_bit_generator_core test passed");
        end else begin
            $display("%0d mismatches", fail_count);
            $display("rsa_pseudorandom_bit_generator_core test failed");
        end
        $finish;
    end
endmodule
